>>> rtl/quaternion_rigid_transform_macros.svh
// assertion macros used by the port checker of the quaternion point transform
// no dependencies; include with the bare file name
`ifndef QUATERNION_RIGID_TRANSFORM_MACROS_SVH
`define QUATERNION_RIGID_TRANSFORM_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define QRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qrt check failed");

// consequent checked in the cycle after the antecedent
`define QRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qrt check failed");

`endif

>>> rtl/qrt_pkg.sv
// types and constants shared by the quaternion point transform
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package qrt_pkg;

   typedef logic signed [17:0] quat_type;
   typedef logic signed [31:0] coord_type;
   typedef logic signed [21:0] entry_type;

   localparam logic [1:0] MODE_RIGID   = 2'd0;
   localparam logic [1:0] MODE_REVERSE = 2'd2;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
   } req_word_type;

   typedef struct packed {
      coord_type result_x;
      coord_type result_y;
      coord_type result_z;
      logic      saturated;
   } rsp_word_type;

   typedef struct packed {
      quat_type   quat_w;
      quat_type   quat_x;
      quat_type   quat_y;
      quat_type   quat_z;
      coord_type  offset_x;
      coord_type  offset_y;
      coord_type  offset_z;
      logic [1:0] mode;
   } cfg_type;

   typedef struct packed {
      entry_type    m00;
      entry_type    m01;
      entry_type    m02;
      entry_type    m10;
      entry_type    m11;
      entry_type    m12;
      entry_type    m20;
      entry_type    m21;
      entry_type    m22;
      req_word_type point;
   } mat_word_type;

endpackage

`default_nettype wire

>>> rtl/qrt_csr.sv
// register file of the quaternion point transform, apb-style write and read
// depends on qrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module qrt_csr
   import qrt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output cfg_type          cfg
);

   localparam logic [2:0] REG_QUAT_W   = 3'd0;
   localparam logic [2:0] REG_QUAT_X   = 3'd1;
   localparam logic [2:0] REG_QUAT_Y   = 3'd2;
   localparam logic [2:0] REG_QUAT_Z   = 3'd3;
   localparam logic [2:0] REG_OFFSET_X = 3'd4;
   localparam logic [2:0] REG_OFFSET_Y = 3'd5;
   localparam logic [2:0] REG_OFFSET_Z = 3'd6;
   localparam logic [2:0] REG_MODE     = 3'd7;

   cfg_type    cfg_ff;
   logic [2:0] index;
   logic       write_en;

   assign index    = paddr[4:2];
   assign write_en = psel & penable & pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quat_w   <= 18'sd65536;
         cfg_ff.quat_x   <= '0;
         cfg_ff.quat_y   <= '0;
         cfg_ff.quat_z   <= '0;
         cfg_ff.offset_x <= '0;
         cfg_ff.offset_y <= '0;
         cfg_ff.offset_z <= '0;
         cfg_ff.mode     <= MODE_RIGID;
      end else if (write_en) begin
         unique case (index)
            REG_QUAT_W:   cfg_ff.quat_w   <= pwdata[17:0];
            REG_QUAT_X:   cfg_ff.quat_x   <= pwdata[17:0];
            REG_QUAT_Y:   cfg_ff.quat_y   <= pwdata[17:0];
            REG_QUAT_Z:   cfg_ff.quat_z   <= pwdata[17:0];
            REG_OFFSET_X: cfg_ff.offset_x <= pwdata;
            REG_OFFSET_Y: cfg_ff.offset_y <= pwdata;
            REG_OFFSET_Z: cfg_ff.offset_z <= pwdata;
            REG_MODE:     cfg_ff.mode     <= pwdata[1:0];
            default:      cfg_ff.mode     <= cfg_ff.mode;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_QUAT_W:   prdata = {{14{cfg_ff.quat_w[17]}}, cfg_ff.quat_w};
         REG_QUAT_X:   prdata = {{14{cfg_ff.quat_x[17]}}, cfg_ff.quat_x};
         REG_QUAT_Y:   prdata = {{14{cfg_ff.quat_y[17]}}, cfg_ff.quat_y};
         REG_QUAT_Z:   prdata = {{14{cfg_ff.quat_z[17]}}, cfg_ff.quat_z};
         REG_OFFSET_X: prdata = cfg_ff.offset_x;
         REG_OFFSET_Y: prdata = cfg_ff.offset_y;
         REG_OFFSET_Z: prdata = cfg_ff.offset_z;
         REG_MODE:     prdata = {30'd0, cfg_ff.mode};
         default:      prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/qrt_matrix.sv
// first two pipeline stages: quaternion component products, then the
// rotation matrix entries in q.16, carried along with the point
// depends on qrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module qrt_matrix
   import qrt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire req_word_type in_word,
   output logic              out_valid,
   input  wire logic         out_ready,
   output mat_word_type      out_word
);

   localparam logic signed [37:0] ONE_Q32 = 38'sd4294967296;

   // 2*(a + b) - 1.0 in q.32, truncated to q.16
   function automatic entry_type diag_entry(input logic signed [35:0] a,
                                            input logic signed [35:0] b);
      logic signed [37:0] s;
      s = 38'(a) + 38'(b);
      s = (s <<< 1) - ONE_Q32;
      return s[37:16];
   endfunction

   // 2*(a +/- b) in q.32, truncated to q.16
   function automatic entry_type cross_entry(input logic signed [35:0] a,
                                             input logic signed [35:0] b,
                                             input logic sub);
      logic signed [37:0] s;
      s = sub ? (38'(a) - 38'(b)) : (38'(a) + 38'(b));
      s = s <<< 1;
      return s[37:16];
   endfunction

   logic                v1_ff;
   req_word_type        point1_ff;
   logic signed [35:0]  ww1_ff, xx1_ff, yy1_ff, zz1_ff;
   logic signed [35:0]  xy1_ff, xz1_ff, yz1_ff, wx1_ff, wy1_ff, wz1_ff;
   logic                v2_ff;
   mat_word_type        mat2_ff;
   mat_word_type        mat2_in;
   logic                adv1, adv2, rev;

   assign adv2      = !v2_ff || out_ready;
   assign adv1      = !v1_ff || adv2;
   assign in_ready  = adv1;
   assign out_valid = v2_ff;
   assign out_word  = mat2_ff;

   // reverse rotation flips the sign of every w-times-vector term
   assign rev = (cfg.mode == MODE_REVERSE);

   always_comb begin
      mat2_in.m00   = diag_entry(ww1_ff, xx1_ff);
      mat2_in.m01   = cross_entry(xy1_ff, wz1_ff, !rev);
      mat2_in.m02   = cross_entry(xz1_ff, wy1_ff, rev);
      mat2_in.m10   = cross_entry(xy1_ff, wz1_ff, rev);
      mat2_in.m11   = diag_entry(ww1_ff, yy1_ff);
      mat2_in.m12   = cross_entry(yz1_ff, wx1_ff, !rev);
      mat2_in.m20   = cross_entry(xz1_ff, wy1_ff, !rev);
      mat2_in.m21   = cross_entry(yz1_ff, wx1_ff, rev);
      mat2_in.m22   = diag_entry(ww1_ff, zz1_ff);
      mat2_in.point = point1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
      end
      if (adv1 && in_valid) begin
         point1_ff <= in_word;
         ww1_ff    <= 36'(cfg.quat_w) * 36'(cfg.quat_w);
         xx1_ff    <= 36'(cfg.quat_x) * 36'(cfg.quat_x);
         yy1_ff    <= 36'(cfg.quat_y) * 36'(cfg.quat_y);
         zz1_ff    <= 36'(cfg.quat_z) * 36'(cfg.quat_z);
         xy1_ff    <= 36'(cfg.quat_x) * 36'(cfg.quat_y);
         xz1_ff    <= 36'(cfg.quat_x) * 36'(cfg.quat_z);
         yz1_ff    <= 36'(cfg.quat_y) * 36'(cfg.quat_z);
         wx1_ff    <= 36'(cfg.quat_w) * 36'(cfg.quat_x);
         wy1_ff    <= 36'(cfg.quat_w) * 36'(cfg.quat_y);
         wz1_ff    <= 36'(cfg.quat_w) * 36'(cfg.quat_z);
      end
      if (adv2 && v1_ff) begin
         mat2_ff <= mat2_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/qrt_rotate.sv
// last three pipeline stages: matrix times point, row sums in q24.16,
// offset and saturation into the output register
// depends on qrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module qrt_rotate
   import qrt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire mat_word_type in_word,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_word_type      out_word
);

   // sum of three q.32 products, truncated to q.16
   function automatic logic signed [39:0] row_sum(input logic signed [53:0] a,
                                                  input logic signed [53:0] b,
                                                  input logic signed [53:0] c);
      logic signed [55:0] s;
      s = 56'(a) + 56'(b) + 56'(c);
      return s[55:16];
   endfunction

   // {clipped flag, value} after adding the offset when use_offset is set
   function automatic logic [32:0] add_clip(input logic signed [39:0] row,
                                            input coord_type offset,
                                            input logic use_offset);
      logic signed [40:0] r;
      r = use_offset ? (41'(row) + 41'(offset)) : 41'(row);
      if (r[40:31] == {10{r[40]}}) begin
         return {1'b0, r[31:0]};
      end
      return {1'b1, r[40] ? 32'h8000_0000 : 32'h7fff_ffff};
   endfunction

   logic                v3_ff, v4_ff, v5_ff;
   logic signed [53:0]  p00_ff, p01_ff, p02_ff;
   logic signed [53:0]  p10_ff, p11_ff, p12_ff;
   logic signed [53:0]  p20_ff, p21_ff, p22_ff;
   logic signed [39:0]  rx4_ff, ry4_ff, rz4_ff;
   rsp_word_type        rsp5_ff;
   rsp_word_type        rsp5_in;
   logic [32:0]         cx, cy, cz;
   logic                adv3, adv4, adv5, rigid;

   assign adv5      = !v5_ff || out_ready;
   assign adv4      = !v4_ff || adv5;
   assign adv3      = !v3_ff || adv4;
   assign in_ready  = adv3;
   assign out_valid = v5_ff;
   assign out_word  = rsp5_ff;
   assign rigid     = (cfg.mode == MODE_RIGID);

   always_comb begin
      cx = add_clip(rx4_ff, cfg.offset_x, rigid);
      cy = add_clip(ry4_ff, cfg.offset_y, rigid);
      cz = add_clip(rz4_ff, cfg.offset_z, rigid);
      rsp5_in.result_x  = cx[31:0];
      rsp5_in.result_y  = cy[31:0];
      rsp5_in.result_z  = cz[31:0];
      rsp5_in.saturated = cx[32] | cy[32] | cz[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv3) begin
            v3_ff <= in_valid;
         end
         if (adv4) begin
            v4_ff <= v3_ff;
         end
         if (adv5) begin
            v5_ff <= v4_ff;
         end
      end
      if (adv3 && in_valid) begin
         p00_ff <= 54'(in_word.m00) * 54'(in_word.point.point_x);
         p01_ff <= 54'(in_word.m01) * 54'(in_word.point.point_y);
         p02_ff <= 54'(in_word.m02) * 54'(in_word.point.point_z);
         p10_ff <= 54'(in_word.m10) * 54'(in_word.point.point_x);
         p11_ff <= 54'(in_word.m11) * 54'(in_word.point.point_y);
         p12_ff <= 54'(in_word.m12) * 54'(in_word.point.point_z);
         p20_ff <= 54'(in_word.m20) * 54'(in_word.point.point_x);
         p21_ff <= 54'(in_word.m21) * 54'(in_word.point.point_y);
         p22_ff <= 54'(in_word.m22) * 54'(in_word.point.point_z);
      end
      if (adv4 && v3_ff) begin
         rx4_ff <= row_sum(p00_ff, p01_ff, p02_ff);
         ry4_ff <= row_sum(p10_ff, p11_ff, p12_ff);
         rz4_ff <= row_sum(p20_ff, p21_ff, p22_ff);
      end
      if (adv5 && v4_ff) begin
         rsp5_ff <= rsp5_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/quaternion_rigid_transform.sv
// quaternion point transform, top level
// Input words (req_) carry one Q16.16 point each; every accepted word gives
// exactly one output word (rsp_) with the rotated point and a clip flag.
// Mode 0 rotates and adds the offset, mode 1 rotates only, mode 2 rotates by
// the conjugate quaternion; code 3 acts as mode 1.
// Pipeline: five register stages (component products, matrix entries,
// matrix-point products, row sums, offset and saturation).
// Throughput: one word per cycle while rsp_ready is high, set by the nine
// matrix-point multipliers working in parallel in a single stage.
// The user must write registers through the apb-style port only while the
// pipeline holds no word (unenforced); stages 1, 2 and 5 read them as words pass.
// Reset: synchronous; empties the pipeline and loads the identity
// quaternion, zero offset and mode 0.
// Stall: when rsp_ready is low the output word holds and the stages behind
// it fill up; req_ready drops only once every stage holds a word.
// Depends on qrt_pkg, qrt_csr, qrt_matrix and qrt_rotate.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_rigid_transform
   import qrt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_data,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [4:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic      [31:0]  prdata,
   output logic              pready
);

   cfg_type      cfg;
   logic         mat_valid;
   logic         mat_ready;
   mat_word_type mat_word;

   qrt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   qrt_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (req_data),
      .out_valid (mat_valid),
      .out_ready (mat_ready),
      .out_word  (mat_word)
   );

   qrt_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mat_valid),
      .in_ready  (mat_ready),
      .in_word   (mat_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/qrt_checker.sv
// port-level checks of the quaternion point transform, bound to the top level
// depends on qrt_pkg and quaternion_rigid_transform_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_rigid_transform_macros.svh"

module qrt_port_checks
   import qrt_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_word_type rsp_data
);

   logic clip_value;

   assign clip_value = (rsp_data.result_x == 32'h7fff_ffff)
                    || (rsp_data.result_x == 32'h8000_0000)
                    || (rsp_data.result_y == 32'h7fff_ffff)
                    || (rsp_data.result_y == 32'h8000_0000)
                    || (rsp_data.result_z == 32'h7fff_ffff)
                    || (rsp_data.result_z == 32'h8000_0000);

   // a stalled output word stays put
   `QRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // a free output lets the whole pipeline move
   `QRT_ASSERT_SAME(a_ready_flow, clock, reset, rsp_ready, req_ready)

   // nothing comes out right after reset
   `QRT_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

   // the clip flag only goes with a coordinate at a rail
   `QRT_ASSERT_SAME(a_clip_rail, clock, reset, rsp_valid && rsp_data.saturated, clip_value)

endmodule

bind quaternion_rigid_transform qrt_port_checks u_checker (.*);

`default_nettype wire
